FILE: hw/rtl/ssds_pkg.sv
// Package for the skid-steer drive sequencer: command, mode and message codes,
// the queued request type, fixed widths and register defaults.
// Used by every module in hw/rtl.
`default_nettype none
package ssds_pkg;

  // Item classes as the front end sorts them
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_VEL   = 3'd1;
  localparam logic [2:0] CMD_ANGLE = 3'd2;
  localparam logic [2:0] CMD_MODE  = 3'd3;
  localparam logic [2:0] CMD_HALT  = 3'd4;

  localparam logic [1:0] MODE_NEUTRAL = 2'd0;
  localparam logic [1:0] MODE_DRIVE   = 2'd1;
  localparam logic [1:0] MODE_CALIB   = 2'd2;

  localparam logic [1:0] MSG_VELOCITY   = 2'd0;
  localparam logic [1:0] MSG_AXIS_STATE = 2'd1;
  localparam logic [1:0] MSG_CTRL_MODE  = 2'd2;

  localparam logic signed [15:0] AXIS_STATE_FULL_CAL = 16'sd3;
  localparam logic signed [15:0] AXIS_STATE_CLOSED   = 16'sd8;
  localparam logic signed [15:0] CTRL_MODE_VELOCITY  = 16'sd2;

  localparam logic [3:0]  STAGE_IDLE = 4'hF;
  localparam logic [19:0] CNT_MAX    = 20'hFFFFF;

  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd180;
  localparam logic signed [9:0]  ANGLE_RIGHT = 10'sd90;
  // floor(x/90) == (x*MIX_RECIP) >> MIX_SHIFT for all x below 2^22
  localparam logic [22:0] MIX_RECIP = 23'd5965233;
  localparam int          MIX_SHIFT = 29;

  localparam int NUM_AXES_DEF = 6;

  // Configuration register indexes
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [2:0] REG_GAIN        = 3'd1;
  localparam logic [2:0] REG_MIN_UPDATE  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_CAL_STAGE   = 3'd4;

  localparam logic [14:0] SPEED_LIMIT_RST = 15'd512;
  localparam logic [14:0] GAIN_RST        = 15'd2048;
  localparam logic [15:0] MIN_UPDATE_RST  = 16'd2;
  localparam logic [19:0] TIMEOUT_RST     = 20'd1000;
  localparam logic [19:0] CAL_STAGE_RST   = 20'd10000;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic [14:0] speed_limit;
    logic [14:0] velocity_gain;
    logic [15:0] min_update_ticks;
    logic [19:0] inactive_timeout_ticks;
    logic [19:0] calibration_stage_ticks;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ssds_front.sv
// Front end: decodes incoming requests, clamps angles, drops requests that
// have no effect, and pushes the rest into the queue. Depends on ssds_pkg.
`default_nettype none
module ssds_front (
  input  wire logic               in_valid,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [15:0] in_value,
  output ssds_pkg::req_t          push_req,
  output logic                    push
);

  logic keep;
  logic signed [15:0] val;

  always_comb begin
    keep = 1'b0;
    val  = in_value;
    unique case (in_command) inside
      ssds_pkg::CMD_TICK, ssds_pkg::CMD_VEL, ssds_pkg::CMD_HALT: begin
        keep = 1'b1;
      end
      ssds_pkg::CMD_ANGLE: begin
        keep = 1'b1;
        if (in_value > ssds_pkg::ANGLE_LIMIT) begin
          val = ssds_pkg::ANGLE_LIMIT;
        end else if (in_value < -ssds_pkg::ANGLE_LIMIT) begin
          val = -ssds_pkg::ANGLE_LIMIT;
        end
      end
      ssds_pkg::CMD_MODE: begin
        // drop mode codes outside neutral, drive, calibrating
        keep = (in_value >= 16'sd0) && (in_value <= 16'sd2);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_req.kind  = in_command;
  assign push_req.value = val;
  assign push           = in_valid && keep;

endmodule
`default_nettype wire

FILE: hw/rtl/ssds_queue.sv
// Two-entry request queue between front end and back end.
// Depends on ssds_pkg for the request type.
`default_nettype none
module ssds_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  ssds_pkg::req_t push_req,
  output logic           full,
  output logic           head_valid,
  output ssds_pkg::req_t head_req,
  input  wire logic      pop
);

  ssds_pkg::req_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_req   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ssds_back.sv
// Back end: executes queued requests (velocity scaling, mixing, drive ticks,
// calibration steps) and drives the registered result channel.
// Depends on ssds_pkg.
`default_nettype none
module ssds_back #(
  parameter int NUM_AXES = ssds_pkg::NUM_AXES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  ssds_pkg::cfg_t cfg,
  input  wire logic      head_valid,
  input  ssds_pkg::req_t head_req,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [2:0]     out_axis,
  output logic [1:0]     out_kind,
  output logic signed [15:0] out_payload,
  output logic           out_last
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VMUL  = 4'd1;
  localparam logic [3:0] S_VSCL  = 4'd2;
  localparam logic [3:0] S_MIX1  = 4'd3;
  localparam logic [3:0] S_MIX2  = 4'd4;
  localparam logic [3:0] S_MIX3  = 4'd5;
  localparam logic [3:0] S_DCHK  = 4'd6;
  localparam logic [3:0] S_DEMIT = 4'd7;
  localparam logic [3:0] S_CMUL  = 4'd8;
  localparam logic [3:0] S_CCHK  = 4'd9;
  localparam logic [3:0] S_CEMIT = 4'd10;

  localparam logic [2:0] LAST_AXIS = 3'(NUM_AXES - 1);
  localparam logic [2:0] AXES      = 3'(NUM_AXES);

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  stage_r, stage_nxt;
  logic signed [15:0] rate_r, rate_nxt;
  logic signed [8:0]  angle_r, angle_nxt;
  logic signed [15:0] left_r, left_nxt, right_r, right_nxt;
  logic signed [15:0] lsent_r, lsent_nxt, rsent_r, rsent_nxt;
  logic [19:0] tsa_r, tsa_nxt, tsu_r, tsu_nxt;
  logic [14:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [29:0] vprod_r, vprod_nxt;
  logic [21:0] mprod_r, mprod_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [22:0] cprod_r, cprod_nxt;
  logic [2:0]  cax_r, cax_nxt;
  logic [1:0]  cidx_r, cidx_nxt;

  logic        ovalid_r, ovalid_nxt;
  logic [2:0]  oaxis_r, oaxis_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic signed [15:0] opay_r, opay_nxt;
  logic        olast_r, olast_nxt;

  logic        out_free;
  logic [19:0] tsa_inc, tsu_inc;
  logic signed [16:0] lim, vclamp;
  logic [14:0] abs_rate;
  logic [7:0]  abs_angle;
  logic signed [9:0] factor;
  logic [6:0]  abs_factor;
  logic [21:0] vsh;
  logic [14:0] vcap;
  logic [44:0] qfull;
  logic signed [15:0] mix_res;
  logic [19:0] stage_len;
  logic [2:0]  s_plus;

  assign out_free = !ovalid_r || out_ready;
  assign tsa_inc  = (tsa_r == ssds_pkg::CNT_MAX) ? tsa_r : tsa_r + 20'd1;
  assign tsu_inc  = (tsu_r == ssds_pkg::CNT_MAX) ? tsu_r : tsu_r + 20'd1;
  assign lim      = signed'({2'b00, cfg.speed_limit});
  assign abs_rate = rate_r[15] ? 15'(-rate_r) : rate_r[14:0];
  assign abs_angle = angle_r[8] ? 8'(-angle_r) : angle_r[7:0];
  assign factor   = ssds_pkg::ANGLE_RIGHT - signed'({2'b00, abs_angle});
  assign abs_factor = factor[9] ? 7'(-factor) : factor[6:0];
  assign vsh      = vprod_r[29:8];
  assign vcap     = (vsh > 22'd32767) ? 15'h7FFF : vsh[14:0];
  assign qfull    = 45'(mprod_r) * 45'(ssds_pkg::MIX_RECIP);
  assign mix_res  = neg_r ? -signed'(quot_r) : signed'(quot_r);
  assign stage_len = (cfg.calibration_stage_ticks == 20'd0) ? 20'd1
                                                            : cfg.calibration_stage_ticks;
  assign s_plus   = (stage_r == ssds_pkg::STAGE_IDLE) ? 3'd0 : stage_r[2:0] + 3'd1;

  always_comb begin
    vclamp = signed'({head_req.value[15], head_req.value});
    if (vclamp > lim) begin
      vclamp = lim;
    end else if (vclamp < -lim) begin
      vclamp = -lim;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    stage_nxt = stage_r;
    rate_nxt  = rate_r;
    angle_nxt = angle_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    lsent_nxt = lsent_r;
    rsent_nxt = rsent_r;
    tsa_nxt   = tsa_r;
    tsu_nxt   = tsu_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    vprod_nxt = vprod_r;
    mprod_nxt = mprod_r;
    quot_nxt  = quot_r;
    k_nxt     = k_r;
    cprod_nxt = cprod_r;
    cax_nxt   = cax_r;
    cidx_nxt  = cidx_r;
    ovalid_nxt = out_ready ? 1'b0 : ovalid_r;
    oaxis_nxt = oaxis_r;
    okind_nxt = okind_r;
    opay_nxt  = opay_r;
    olast_nxt = olast_r;
    pop       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head_req.kind)
            ssds_pkg::CMD_TICK: begin
              tsa_nxt = tsa_inc;
              tsu_nxt = tsu_inc;
              if (mode_r == ssds_pkg::MODE_CALIB) begin
                state_nxt = S_CMUL;
              end else begin
                if (tsa_inc > cfg.inactive_timeout_ticks) begin
                  // inactivity: zero rate, which mixes to zero on both sides
                  tsa_nxt   = '0;
                  rate_nxt  = '0;
                  left_nxt  = '0;
                  right_nxt = '0;
                end
                state_nxt = S_DCHK;
              end
            end
            ssds_pkg::CMD_VEL: begin
              tsa_nxt   = '0;
              neg_nxt   = vclamp[16];
              mag_nxt   = vclamp[16] ? 15'(-vclamp) : vclamp[14:0];
              state_nxt = S_VMUL;
            end
            ssds_pkg::CMD_ANGLE: begin
              tsa_nxt   = '0;
              angle_nxt = head_req.value[8:0];
              state_nxt = S_MIX1;
            end
            ssds_pkg::CMD_MODE: begin
              if (mode_r != ssds_pkg::MODE_CALIB) begin
                tsa_nxt  = '0;
                mode_nxt = head_req.value[1:0];
                state_nxt = (head_req.value[1:0] == ssds_pkg::MODE_CALIB) ? S_CMUL : S_DCHK;
              end
            end
            ssds_pkg::CMD_HALT: begin
              rate_nxt  = '0;
              angle_nxt = '0;
              left_nxt  = '0;
              right_nxt = '0;
              if (mode_r != ssds_pkg::MODE_CALIB) begin
                tsa_nxt   = '0;
                mode_nxt  = ssds_pkg::MODE_NEUTRAL;
                state_nxt = S_DCHK;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_VMUL: begin
        vprod_nxt = 30'(mag_r) * 30'(cfg.velocity_gain);
        state_nxt = S_VSCL;
      end
      S_VSCL: begin
        rate_nxt  = neg_r ? -signed'({1'b0, vcap}) : signed'({1'b0, vcap});
        state_nxt = S_MIX1;
      end
      S_MIX1: begin
        if (angle_r == 9'sd0) begin
          left_nxt  = rate_r;
          right_nxt = rate_r;
          state_nxt = S_IDLE;
        end else begin
          mprod_nxt = 22'(abs_rate) * 22'(abs_factor);
          neg_nxt   = rate_r[15] ^ factor[9];
          state_nxt = S_MIX2;
        end
      end
      S_MIX2: begin
        quot_nxt  = qfull[ssds_pkg::MIX_SHIFT +: 16];
        state_nxt = S_MIX3;
      end
      S_MIX3: begin
        if (angle_r[8]) begin
          left_nxt  = mix_res;
          right_nxt = rate_r;
        end else begin
          left_nxt  = rate_r;
          right_nxt = mix_res;
        end
        state_nxt = S_IDLE;
      end
      S_DCHK: begin
        if ((tsu_r < 20'(cfg.min_update_ticks)) ||
            ((left_r == lsent_r) && (right_r == rsent_r))) begin
          state_nxt = S_IDLE;
        end else begin
          if (mode_r == ssds_pkg::MODE_NEUTRAL) begin
            lsent_nxt = '0;
            rsent_nxt = '0;
          end else begin
            lsent_nxt = left_r;
            rsent_nxt = right_r;
          end
          tsu_nxt   = '0;
          k_nxt     = LAST_AXIS;
          state_nxt = S_DEMIT;
        end
      end
      S_DEMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oaxis_nxt  = k_r;
          okind_nxt  = ssds_pkg::MSG_VELOCITY;
          // odd axes sit on the left side and turn the other way
          opay_nxt   = k_r[0] ? -lsent_r : rsent_r;
          olast_nxt  = (k_r == 3'd0);
          if (k_r == 3'd0) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r - 3'd1;
          end
        end
      end
      S_CMUL: begin
        if (stage_r == ssds_pkg::STAGE_IDLE) begin
          tsu_nxt = '0;
        end
        cprod_nxt = 23'(s_plus) * 23'(stage_len);
        cax_nxt   = s_plus;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        // advance when (stage+1)*len <= elapsed, i.e. stage < elapsed/len
        if (cprod_r <= 23'(tsu_r)) begin
          if (cax_r == AXES) begin
            mode_nxt  = ssds_pkg::MODE_NEUTRAL;
            tsu_nxt   = '0;
            tsa_nxt   = '0;
            stage_nxt = ssds_pkg::STAGE_IDLE;
            cidx_nxt  = 2'd1;
          end else begin
            stage_nxt = {1'b0, cax_r};
            cidx_nxt  = 2'd0;
          end
          state_nxt = S_CEMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CEMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          case (cidx_r)
            2'd0: begin
              oaxis_nxt = cax_r;
              okind_nxt = ssds_pkg::MSG_AXIS_STATE;
              opay_nxt  = ssds_pkg::AXIS_STATE_FULL_CAL;
              olast_nxt = (cax_r == 3'd0);
              cidx_nxt  = 2'd1;
              if (cax_r == 3'd0) state_nxt = S_IDLE;
            end
            2'd1: begin
              oaxis_nxt = cax_r - 3'd1;
              okind_nxt = ssds_pkg::MSG_AXIS_STATE;
              opay_nxt  = ssds_pkg::AXIS_STATE_CLOSED;
              olast_nxt = 1'b0;
              cidx_nxt  = 2'd2;
            end
            default: begin
              oaxis_nxt = cax_r - 3'd1;
              okind_nxt = ssds_pkg::MSG_CTRL_MODE;
              opay_nxt  = ssds_pkg::CTRL_MODE_VELOCITY;
              olast_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= ssds_pkg::MODE_CALIB;
      stage_r  <= ssds_pkg::STAGE_IDLE;
      rate_r   <= '0;
      angle_r  <= '0;
      left_r   <= '0;
      right_r  <= '0;
      lsent_r  <= '0;
      rsent_r  <= '0;
      tsa_r    <= '0;
      tsu_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      stage_r  <= stage_nxt;
      rate_r   <= rate_nxt;
      angle_r  <= angle_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      lsent_r  <= lsent_nxt;
      rsent_r  <= rsent_nxt;
      tsa_r    <= tsa_nxt;
      tsu_r    <= tsu_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    vprod_r <= vprod_nxt;
    mprod_r <= mprod_nxt;
    quot_r  <= quot_nxt;
    k_r     <= k_nxt;
    cprod_r <= cprod_nxt;
    cax_r   <= cax_nxt;
    cidx_r  <= cidx_nxt;
    oaxis_r <= oaxis_nxt;
    okind_r <= okind_nxt;
    opay_r  <= opay_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid   = ovalid_r;
  assign out_axis    = oaxis_r;
  assign out_kind    = okind_r;
  assign out_payload = opay_r;
  assign out_last    = olast_r;

  a_stage_only_calib: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r != ssds_pkg::STAGE_IDLE) |-> (mode_r == ssds_pkg::MODE_CALIB))
    else $error("calibration stage active outside calibrating mode");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ssds_pkg::STAGE_IDLE) || (stage_r < 4'(NUM_AXES)))
    else $error("calibration stage out of range");

  a_straight_mix: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (angle_r == 9'sd0)) |-> ((left_r == rate_r) && (right_r == rate_r)))
    else $error("straight-ahead targets differ from rate");

endmodule
`default_nettype wire

FILE: hw/rtl/skid_steer_drive_sequencer_top.sv
// The back end takes each request from the queue head while it is idle; once the
// first message of a drive update or calibration step is valid, one follows per cycle
// while out_tready allows. A request is taken only after the last one is done; dropped
// requests never enter the 2-entry queue.
// Reset (synchronous, rst_n low): registers to defaults, mode calibrating,
// calibration idle, targets and counters zero, queue and result channel empty.
`default_nettype none
module skid_steer_drive_sequencer_top #(
  parameter int NUM_AXES = ssds_pkg::NUM_AXES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] value
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] axis, [18:3] payload, rest zero
  output logic [1:0]       out_tuser,  // [1:0] message_kind
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  ssds_pkg::cfg_t cfg_r;
  ssds_pkg::req_t push_req, head_req;
  logic push, full, head_valid, pop, wr_en;
  logic [2:0] reg_idx;
  logic [2:0] o_axis;
  logic signed [15:0] o_payload;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit             <= ssds_pkg::SPEED_LIMIT_RST;
      cfg_r.velocity_gain           <= ssds_pkg::GAIN_RST;
      cfg_r.min_update_ticks        <= ssds_pkg::MIN_UPDATE_RST;
      cfg_r.inactive_timeout_ticks  <= ssds_pkg::TIMEOUT_RST;
      cfg_r.calibration_stage_ticks <= ssds_pkg::CAL_STAGE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ssds_pkg::REG_SPEED_LIMIT: cfg_r.speed_limit            <= cfg_pwdata[14:0];
        ssds_pkg::REG_GAIN:       cfg_r.velocity_gain           <= cfg_pwdata[14:0];
        ssds_pkg::REG_MIN_UPDATE: cfg_r.min_update_ticks        <= cfg_pwdata[15:0];
        ssds_pkg::REG_TIMEOUT:    cfg_r.inactive_timeout_ticks  <= cfg_pwdata[19:0];
        ssds_pkg::REG_CAL_STAGE:  cfg_r.calibration_stage_ticks <= cfg_pwdata[19:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssds_pkg::REG_SPEED_LIMIT: cfg_prdata = 32'(cfg_r.speed_limit);
      ssds_pkg::REG_GAIN:       cfg_prdata = 32'(cfg_r.velocity_gain);
      ssds_pkg::REG_MIN_UPDATE: cfg_prdata = 32'(cfg_r.min_update_ticks);
      ssds_pkg::REG_TIMEOUT:    cfg_prdata = 32'(cfg_r.inactive_timeout_ticks);
      ssds_pkg::REG_CAL_STAGE:  cfg_prdata = 32'(cfg_r.calibration_stage_ticks);
      default:                  cfg_prdata = '0;
    endcase
  end

  assign in_tready = !full;

  ssds_front u_front (
    .in_valid   (in_tvalid && in_tready),
    .in_command (in_tuser),
    .in_value   (in_tdata),
    .push_req   (push_req),
    .push       (push)
  );

  ssds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .full       (full),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop)
  );

  ssds_back #(
    .NUM_AXES (NUM_AXES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head_valid  (head_valid),
    .head_req    (head_req),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_axis    (o_axis),
    .out_kind    (out_tuser),
    .out_payload (o_payload),
    .out_last    (out_tlast)
  );

  assign out_tdata = {5'b00000, o_payload, o_axis};

endmodule
`default_nettype wire
